### design/gas_pkg.sv
package gas_pkg;

   // input word
   typedef struct packed {
      logic [1:0]  opcode;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic        blocked;
      logic [11:0] path_index;
   } req_word_type;

   // result word
   typedef struct packed {
      logic        found;
      logic [12:0] path_length;
      logic [5:0]  path_x;
      logic [5:0]  path_y;
   } rsp_word_type;

   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_SEARCH = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [2:0] CSR_WIDTH_USED  = 3'd0;
   localparam logic [2:0] CSR_HEIGHT_USED = 3'd1;
   localparam logic [2:0] CSR_START_X     = 3'd2;
   localparam logic [2:0] CSR_START_Y     = 3'd3;
   localparam logic [2:0] CSR_GOAL_X      = 3'd4;
   localparam logic [2:0] CSR_GOAL_Y      = 3'd5;

   localparam logic [16:0] STEP_STRAIGHT = 17'd10;
   localparam logic [16:0] STEP_DIAG     = 17'd14;
   localparam logic [15:0] G_MAX         = 16'hFFFF;
   localparam logic [23:0] F_MAX         = 24'hFFFFFF;
   localparam int          F_BITS        = 24;

endpackage

### design/gas_ram.sv
module gas_ram import gas_pkg::*; #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [(1 << ADDR_W)];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### design/gas_isqrt.sv
module gas_isqrt import gas_pkg::*; #(
   parameter int RAD_W = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RAD_W-1:0]     radicand,
   output logic                 done,
   output logic [RAD_W/2-1:0]   root
);

   localparam int QW   = RAD_W / 2;
   localparam int REMW = QW + 2;
   localparam int CNTW = $clog2(QW + 1);

   logic [RAD_W-1:0] rad_ff, rad_in;
   logic [REMW-1:0]  rem_ff, rem_in;
   logic [QW-1:0]    root_ff, root_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [REMW+1:0]  rem_t;
   logic [REMW+1:0]  trial;
   logic             ge;

   // one root bit per cycle, restoring
   assign rem_t = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign ge    = rem_t >= trial;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNTW'(QW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? REMW'(rem_t - trial) : REMW'(rem_t);
         root_in = {root_ff[QW-2:0], ge};
         rad_in  = rad_ff << 2;
         cnt_in  = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### design/grid_astar_path_search.sv
// A* path search over a square grid with 8-way moves.
//
// Channels: req_* carries one command word (write a map cell, run a search,
// read one path cell), rsp_* returns exactly one result word per command.
// Both use valid/stall; a word moves on a clock edge with valid high and
// stall low. csr_* is a write-only register port (index 0..5: width, height,
// start x/y, goal x/y), which the user is to write only while the block is
// idle; the block itself does not enforce this.
//
// A map write reads the cell and writes it back; a path read reads the path
// store. A search sweeps the node memory to clear its marks, then for each
// expanded cell closes it, visits its nine-cell neighborhood (a neighbor
// that gets a new estimate waits for the bit-serial square root), and scans
// the open set over width*height cells through the node memory read port,
// which dominates. The path is traced back cell by cell through parents.
// One command is in work at a time; a finished result sits in the output
// register, so the next command is taken while the receiver stalls, and the
// block waits only when a second result is ready before the first is taken.
// Reset: sync, active high. After reset the map is swept to free, one cell
// per cycle over the whole node memory, with req_stall high; csr writes are
// taken throughout.
module grid_astar_path_search import gas_pkg::*; #(
   parameter int GRID_SIDE      = 64,
   parameter int HEUR_FRAC_BITS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_index,
   input  logic [6:0]   csr_wdata
);

   localparam int CW     = $clog2(GRID_SIDE);      // coordinate bits
   localparam int AW     = 2 * CW;                 // cell address {y,x}
   localparam int MEMD   = 1 << AW;
   localparam int NCELLS = GRID_SIDE * GRID_SIDE;
   localparam int RADR   = 2 * CW + 1 + 2 * HEUR_FRAC_BITS;
   localparam int RAD_W  = RADR + (RADR % 2);
   localparam int QW     = RAD_W / 2;
   localparam int SUMW   = (17 + HEUR_FRAC_BITS > 25) ? 17 + HEUR_FRAC_BITS : 25;

   typedef struct packed {
      logic             blocked;
      logic             is_open;
      logic             is_closed;
      logic [15:0]      g;
      logic [23:0]      f;
      logic [AW-1:0]    parent;
   } node_type;

   localparam int NW = $bits(node_type);

   typedef enum logic [17:0] {
      S_INIT     = 18'b000000000000000001,
      S_IDLE     = 18'b000000000000000010,
      S_WR_RD    = 18'b000000000000000100,
      S_PREAD    = 18'b000000000000001000,
      S_CLR      = 18'b000000000000010000,
      S_CLOSE    = 18'b000000000000100000,
      S_CLOSE_W  = 18'b000000000001000000,
      S_NB       = 18'b000000000010000000,
      S_NB_RD    = 18'b000000000100000000,
      S_HSQ      = 18'b000000001000000000,
      S_HSTART   = 18'b000000010000000000,
      S_HWAIT    = 18'b000000100000000000,
      S_SCAN     = 18'b000001000000000000,
      S_SCAN_END = 18'b000010000000000000,
      S_PICK     = 18'b000100000000000000,
      S_WALK     = 18'b001000000000000000,
      S_WALK_RD  = 18'b010000000000000000,
      S_DONE     = 18'b100000000000000000
   } state_type;

   // control
   state_type     state_ff, state_in;
   req_word_type  req_ff, req_in;
   logic [6:0]    width_ff, width_in, height_ff, height_in;
   logic [5:0]    start_x_ff, start_x_in, start_y_ff, start_y_in;
   logic [5:0]    goal_x_ff, goal_x_in, goal_y_ff, goal_y_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic [AW:0]   open_cnt_ff, open_cnt_in;
   logic          found_ff, found_in;
   logic [AW:0]   path_cnt_ff, path_cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          sc_vld_ff, sc_vld_in;
   logic          have_ff, have_in;

   // datapath
   logic [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [15:0]   cur_g_ff, cur_g_in;
   logic [1:0]    nx_ff, nx_in, ny_ff, ny_in;
   logic [CW-1:0] nbx_ff, nbx_in, nby_ff, nby_in;
   logic [15:0]   g_new_ff, g_new_in;
   node_type      nd_ff, nd_in;
   logic [CW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [AW:0]   sq_ff, sq_in;
   logic [CW-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [AW-1:0] sc_addr_ff, sc_addr_in;
   logic [AW-1:0] best_ff, best_in;
   logic [23:0]   best_f_ff, best_f_in;
   logic [15:0]   best_g_ff, best_g_in;
   logic [AW-1:0] walk_ff, walk_in;
   logic [AW:0]   steps_ff, steps_in;
   logic [5:0]    px_ff, px_in, py_ff, py_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   // memory ports
   logic          node_wr_en;
   logic [AW-1:0] node_wr_addr, node_rd_addr;
   node_type      node_wr, node_rd;
   logic [NW-1:0] node_rd_data;
   logic          path_wr_en;
   logic [AW-1:0] path_rd_addr;
   logic [AW-1:0] path_rd_data;

   // sqrt unit
   logic             sqrt_start, sqrt_done;
   logic [RAD_W-1:0] sqrt_rad;
   logic [QW-1:0]    sqrt_root;

   // helpers
   logic [CW:0]     w_eff, h_eff;
   logic [CW-1:0]   gx, gy, stx, sty;
   logic [AW-1:0]   from_addr, goal_addr, start_addr;
   logic [CW+1:0]   xs, ys;
   logic            nb_in_region, diag, is_goal_nb, is_self_nb;
   logic [16:0]     g_sum;
   logic [15:0]     g_step;
   logic [AW:0]     dxw, dyw;
   logic [SUMW-1:0] f_sum;
   logic [23:0]     f_sat;
   logic            accept, out_free, nb_next, better;
   logic [AW:0]     path_pos;

   gas_ram #(.DATA_W(NW), .ADDR_W(AW)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_wr_en),
      .wr_addr (node_wr_addr),
      .wr_data (node_wr),
      .rd_addr (node_rd_addr),
      .rd_data (node_rd_data)
   );

   gas_ram #(.DATA_W(AW), .ADDR_W(AW)) u_path_ram (
      .clock   (clock),
      .wr_en   (path_wr_en),
      .wr_addr (steps_ff[AW-1:0]),
      .wr_data (walk_ff),
      .rd_addr (path_rd_addr),
      .rd_data (path_rd_data)
   );

   gas_isqrt #(.RAD_W(RAD_W)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign node_rd = node_type'(node_rd_data);

   // size registers: 0 acts as 1, above the grid acts as the grid side
   always_comb begin
      if (width_ff == 7'd0) w_eff = (CW+1)'(1);
      else if (32'(width_ff) > GRID_SIDE) w_eff = (CW+1)'(GRID_SIDE);
      else w_eff = (CW+1)'(width_ff);
      if (height_ff == 7'd0) h_eff = (CW+1)'(1);
      else if (32'(height_ff) > GRID_SIDE) h_eff = (CW+1)'(GRID_SIDE);
      else h_eff = (CW+1)'(height_ff);
   end

   assign gx         = CW'(goal_x_ff);
   assign gy         = CW'(goal_y_ff);
   assign stx        = CW'(start_x_ff);
   assign sty        = CW'(start_y_ff);
   assign from_addr  = {cy_ff, cx_ff};
   assign goal_addr  = {gy, gx};
   assign start_addr = {sty, stx};

   // neighbor at offset (nx-1, ny-1); negative wraps into the top bit
   assign xs = (CW+2)'(cx_ff) + (CW+2)'(nx_ff) - (CW+2)'(1);
   assign ys = (CW+2)'(cy_ff) + (CW+2)'(ny_ff) - (CW+2)'(1);
   assign nb_in_region = !xs[CW+1] && !ys[CW+1] && (xs[CW:0] < w_eff)
                         && (ys[CW:0] < h_eff);
   assign diag       = (nx_ff != 2'd1) && (ny_ff != 2'd1);
   assign is_goal_nb = (nbx_ff == gx) && (nby_ff == gy);
   assign is_self_nb = (nbx_ff == cx_ff) && (nby_ff == cy_ff);
   assign g_sum      = {1'b0, cur_g_ff} + (diag ? STEP_DIAG : STEP_STRAIGHT);
   assign g_step     = g_sum[16] ? G_MAX : g_sum[15:0];

   assign dxw      = (AW+1)'(dx_ff);
   assign dyw      = (AW+1)'(dy_ff);
   assign sqrt_rad = RAD_W'(sq_ff) << (2 * HEUR_FRAC_BITS);

   // f = g * 2^F + h, saturating at 24 bits
   assign f_sum = (SUMW'(g_new_ff) << HEUR_FRAC_BITS) + SUMW'(sqrt_root);
   assign f_sat = (|f_sum[SUMW-1:F_BITS]) ? F_MAX : f_sum[F_BITS-1:0];

   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign path_pos  = path_cnt_ff - (AW+1)'(1) - (AW+1)'(req_word.path_index);
   assign path_rd_addr = path_pos[AW-1:0];
   assign better    = node_rd.is_open && (!have_ff || (node_rd.f < best_f_ff));

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      goal_x_in    = goal_x_ff;
      goal_y_in    = goal_y_ff;
      cnt_in       = cnt_ff;
      open_cnt_in  = open_cnt_ff;
      found_in     = found_ff;
      path_cnt_in  = path_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      sc_vld_in    = 1'b0;
      have_in      = have_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cur_g_in     = cur_g_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      nbx_in       = nbx_ff;
      nby_in       = nby_ff;
      g_new_in     = g_new_ff;
      nd_in        = nd_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sq_in        = sq_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      sc_addr_in   = sc_addr_ff;
      best_in      = best_ff;
      best_f_in    = best_f_ff;
      best_g_in    = best_g_ff;
      walk_in      = walk_ff;
      steps_in     = steps_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      rsp_word_in  = rsp_word_ff;
      node_wr_en   = 1'b0;
      node_wr_addr = '0;
      node_wr      = '0;
      node_rd_addr = '0;
      path_wr_en   = 1'b0;
      sqrt_start   = 1'b0;
      nb_next      = 1'b0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WIDTH_USED:  width_in   = csr_wdata;
            CSR_HEIGHT_USED: height_in  = csr_wdata;
            CSR_START_X:     start_x_in = csr_wdata[5:0];
            CSR_START_Y:     start_y_in = csr_wdata[5:0];
            CSR_GOAL_X:      goal_x_in  = csr_wdata[5:0];
            CSR_GOAL_Y:      goal_y_in  = csr_wdata[5:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // running minimum over the scan, one node per cycle
      if (sc_vld_ff && better) begin
         have_in   = 1'b1;
         best_in   = sc_addr_ff;
         best_f_in = node_rd.f;
         best_g_in = node_rd.g;
      end

      unique case (state_ff)
         S_INIT: begin
            node_wr_en   = 1'b1;
            node_wr_addr = cnt_ff[AW-1:0];
            if (cnt_ff == (AW+1)'(MEMD - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + (AW+1)'(1);
            end
         end
         S_IDLE: begin
            node_rd_addr = {CW'(req_word.cell_y), CW'(req_word.cell_x)};
            if (accept) begin
               req_in   = req_word;
               px_in    = '0;
               py_in    = '0;
               state_in = S_DONE;
               priority if (req_word.opcode == OP_WRITE) begin
                  if ((32'(req_word.cell_x) < GRID_SIDE)
                      && (32'(req_word.cell_y) < GRID_SIDE)) begin
                     state_in = S_WR_RD;
                  end
               end else if (req_word.opcode == OP_SEARCH) begin
                  found_in    = 1'b0;
                  path_cnt_in = '0;
                  open_cnt_in = '0;
                  cnt_in      = '0;
                  if ((32'(start_x_ff) < 32'(w_eff)) && (32'(start_y_ff) < 32'(h_eff))
                      && (32'(goal_x_ff) < 32'(w_eff))
                      && (32'(goal_y_ff) < 32'(h_eff))) begin
                     state_in = S_CLR;
                  end
               end else if (req_word.opcode == OP_READ) begin
                  if (32'(req_word.path_index) < 32'(path_cnt_ff)) begin
                     state_in = S_PREAD;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_WR_RD: begin
            node_wr_en   = 1'b1;
            node_wr_addr = {CW'(req_ff.cell_y), CW'(req_ff.cell_x)};
            node_wr      = node_rd;
            node_wr.blocked = req_ff.blocked;
            state_in     = S_DONE;
         end
         S_PREAD: begin
            px_in    = 6'(path_rd_data[CW-1:0]);
            py_in    = 6'(path_rd_data[AW-1:CW]);
            state_in = S_DONE;
         end
         S_CLR: begin
            // read entry n, write back entry n-1 with its marks cleared
            node_rd_addr = cnt_ff[AW-1:0];
            if (cnt_ff != '0) begin
               node_wr_en   = 1'b1;
               node_wr_addr = AW'(cnt_ff - (AW+1)'(1));
               node_wr      = node_rd;
               node_wr.is_open   = 1'b0;
               node_wr.is_closed = 1'b0;
            end
            if (cnt_ff == (AW+1)'(MEMD)) begin
               cx_in    = stx;
               cy_in    = sty;
               cur_g_in = '0;
               state_in = S_CLOSE;
            end else begin
               cnt_in = cnt_ff + (AW+1)'(1);
            end
         end
         S_CLOSE: begin
            node_rd_addr = from_addr;
            state_in     = S_CLOSE_W;
         end
         S_CLOSE_W: begin
            node_wr_en   = 1'b1;
            node_wr_addr = from_addr;
            node_wr      = node_rd;
            node_wr.is_open   = 1'b0;
            node_wr.is_closed = 1'b1;
            nx_in        = '0;
            ny_in        = '0;
            state_in     = S_NB;
         end
         S_NB: begin
            node_rd_addr = {ys[CW-1:0], xs[CW-1:0]};
            if (nb_in_region) begin
               nbx_in   = xs[CW-1:0];
               nby_in   = ys[CW-1:0];
               state_in = S_NB_RD;
            end else begin
               nb_next = 1'b1;
            end
         end
         S_NB_RD: begin
            if (is_goal_nb) begin
               // goal next door: zero cost so it is taken next
               node_wr_en   = 1'b1;
               node_wr_addr = {nby_ff, nbx_ff};
               node_wr      = node_rd;
               node_wr.is_open = 1'b1;
               node_wr.g       = '0;
               node_wr.f       = '0;
               node_wr.parent  = from_addr;
               if (!node_rd.is_open) begin
                  open_cnt_in = open_cnt_ff + (AW+1)'(1);
               end
               nb_next = 1'b1;
            end else if (node_rd.blocked || is_self_nb || node_rd.is_closed) begin
               nb_next = 1'b1;
            end else if (node_rd.is_open && (node_rd.g <= g_step)) begin
               nb_next = 1'b1;
            end else begin
               g_new_in = g_step;
               nd_in    = node_rd;
               dx_in    = (nbx_ff >= gx) ? nbx_ff - gx : gx - nbx_ff;
               dy_in    = (nby_ff >= gy) ? nby_ff - gy : gy - nby_ff;
               state_in = S_HSQ;
            end
         end
         S_HSQ: begin
            sq_in    = dxw * dxw + dyw * dyw;
            state_in = S_HSTART;
         end
         S_HSTART: begin
            sqrt_start = 1'b1;
            state_in   = S_HWAIT;
         end
         S_HWAIT: begin
            if (sqrt_done) begin
               node_wr_en   = 1'b1;
               node_wr_addr = {nby_ff, nbx_ff};
               node_wr      = nd_ff;
               node_wr.is_open = 1'b1;
               node_wr.g       = g_new_ff;
               node_wr.f       = f_sat;
               node_wr.parent  = from_addr;
               if (!nd_ff.is_open) begin
                  open_cnt_in = open_cnt_ff + (AW+1)'(1);
               end
               nb_next = 1'b1;
            end
         end
         S_SCAN: begin
            node_rd_addr = {sy_ff, sx_ff};
            sc_vld_in    = 1'b1;
            sc_addr_in   = {sy_ff, sx_ff};
            if ((CW+1)'(sy_ff) == h_eff - (CW+1)'(1)) begin
               sy_in = '0;
               if ((CW+1)'(sx_ff) == w_eff - (CW+1)'(1)) begin
                  state_in = S_SCAN_END;
               end else begin
                  sx_in = sx_ff + CW'(1);
               end
            end else begin
               sy_in = sy_ff + CW'(1);
            end
         end
         S_SCAN_END: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            priority if (!have_ff) begin
               state_in = S_DONE;
            end else if (best_ff == goal_addr) begin
               walk_in  = goal_addr;
               steps_in = '0;
               state_in = S_WALK;
            end else begin
               cx_in       = best_ff[CW-1:0];
               cy_in       = best_ff[AW-1:CW];
               cur_g_in    = best_g_ff;
               open_cnt_in = open_cnt_ff - (AW+1)'(1);
               state_in    = S_CLOSE;
            end
         end
         S_WALK: begin
            // path store holds goal first; reads index from the far end
            path_wr_en   = 1'b1;
            node_rd_addr = walk_ff;
            priority if (walk_ff == start_addr) begin
               path_cnt_in = steps_ff + (AW+1)'(1);
               found_in    = 1'b1;
               state_in    = S_DONE;
            end else if (steps_ff >= (AW+1)'(NCELLS - 1)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            walk_in  = node_rd.parent;
            steps_in = steps_ff + (AW+1)'(1);
            state_in = S_WALK;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.found       = found_ff;
               rsp_word_in.path_length = 13'(path_cnt_ff);
               rsp_word_in.path_x      = px_ff;
               rsp_word_in.path_y      = py_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // step through the 3x3 neighborhood, row by row
      if (nb_next) begin
         if (nx_ff == 2'd2) begin
            nx_in = '0;
            if (ny_ff == 2'd2) begin
               ny_in   = '0;
               sx_in   = '0;
               sy_in   = '0;
               have_in = 1'b0;
               state_in = (open_cnt_in == '0) ? S_DONE : S_SCAN;
            end else begin
               ny_in    = ny_ff + 2'd1;
               state_in = S_NB;
            end
         end else begin
            nx_in    = nx_ff + 2'd1;
            state_in = S_NB;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         width_ff     <= 7'd64;
         height_ff    <= 7'd64;
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         goal_x_ff    <= '0;
         goal_y_ff    <= '0;
         open_cnt_ff  <= '0;
         found_ff     <= 1'b0;
         path_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         sc_vld_ff    <= 1'b0;
         have_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         start_x_ff   <= start_x_in;
         start_y_ff   <= start_y_in;
         goal_x_ff    <= goal_x_in;
         goal_y_ff    <= goal_y_in;
         open_cnt_ff  <= open_cnt_in;
         found_ff     <= found_in;
         path_cnt_ff  <= path_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         sc_vld_ff    <= sc_vld_in;
         have_ff      <= have_in;
      end
      req_ff      <= req_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cur_g_ff    <= cur_g_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      nbx_ff      <= nbx_in;
      nby_ff      <= nby_in;
      g_new_ff    <= g_new_in;
      nd_ff       <= nd_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sq_ff       <= sq_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      sc_addr_ff  <= sc_addr_in;
      best_ff     <= best_in;
      best_f_ff   <= best_f_in;
      best_g_ff   <= best_g_in;
      walk_ff     <= walk_in;
      steps_ff    <= steps_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### design/gas_checker.sv
module gas_checker import gas_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_word_type req_word,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_word,
   input logic         csr_wr_en,
   input logic [2:0]   csr_index,
   input logic [6:0]   csr_wdata
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   a_miss_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.found |-> rsp_word.path_length == 13'd0
         && rsp_word.path_x == 6'd0 && rsp_word.path_y == 6'd0)
      else $error("no path but length or cell nonzero");

   a_hit_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.found |-> rsp_word.path_length != 13'd0)
      else $error("path found with zero length");

endmodule

bind grid_astar_path_search gas_checker u_gas_checker (.*);

### dv/grid_astar_path_search_test.sv
`timescale 1ns / 100ps

module grid_astar_path_search_test;
   import gas_pkg::*;

   localparam logic [1:0] OP_NOP = 2'd3;   // no action, status only
   localparam int SIDE       = 64;
   localparam int CELLS      = SIDE * SIDE;
   localparam int IDLE_LIMIT = 300000;      // cycles with no word moving
   localparam int ITEM_GOAL  = 140;         // directed plus random

   typedef enum logic {ROW_CMD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [2:0]   idx;
      logic [6:0]   val;
      req_word_type word;
      bit           typed;
      rsp_word_type rsp;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_wr_en = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [6:0]   csr_wdata = '0;

   grid_astar_path_search u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Search model: own copy of map, node tables, path and registers
   // ---------------------------------------------------------------
   bit          map_blk  [CELLS];
   logic [15:0] node_g   [CELLS];
   logic [23:0] node_f   [CELLS];
   logic [11:0] node_par [CELLS];
   bit          node_opn [CELLS];
   bit          node_cls [CELLS];
   logic [11:0] path_mem [CELLS];
   logic [12:0] path_cnt;
   bit          path_ok;
   int          open_cnt;
   logic [6:0]  reg_w, reg_h;
   logic [5:0]  reg_sx, reg_sy, reg_gx, reg_gy;

   rsp_word_type sched_q[$];   // results owed by the block, oldest first
   int  errors;
   int  items_sent;
   bit  quiet;                 // sender: no gaps
   bit  hold_long;             // receiver: one long stall

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Euclidean distance to goal in Q.8
   function automatic longint unsigned dist_q8(int x, int y);
      longint unsigned dx, dy;
      dx = (x > reg_gx) ? x - reg_gx : reg_gx - x;
      dy = (y > reg_gy) ? y - reg_gy : reg_gy - y;
      return int_sqrt((dx * dx + dy * dy) << 16);
   endfunction

   function automatic int clamp_dim(logic [6:0] d);
      if (d == 0) return 1;
      if (d > SIDE) return SIDE;
      return int'(d);
   endfunction

   function automatic void expand_cell(int cx, int cy, int w, int h);
      int from, c, gn;
      longint unsigned fv;
      from = cy * SIDE + cx;
      node_cls[from] = 1;
      for (int y = cy - 1; y <= cy + 1; y++) begin
         for (int x = cx - 1; x <= cx + 1; x++) begin
            if (x < 0 || y < 0 || x >= w || y >= h) continue;
            c = y * SIDE + x;
            // goal as neighbor: cost zero, opened even when blocked
            if (x == reg_gx && y == reg_gy) begin
               node_par[c] = 12'(from);
               node_g[c] = 16'd0;
               node_f[c] = 24'd0;
               if (!node_opn[c]) begin
                  node_opn[c] = 1;
                  open_cnt++;
               end
               continue;
            end
            if (map_blk[c] || c == from || node_cls[c]) continue;
            gn = node_g[from] + ((x != cx && y != cy) ? 14 : 10);
            if (gn > 65535) gn = 65535;
            if (node_opn[c] && node_g[c] <= gn) continue;
            node_g[c] = 16'(gn);
            fv = (longint'(gn) << 8) + dist_q8(x, y);
            node_f[c] = (fv > 64'hFFFFFF) ? 24'hFFFFFF : fv[23:0];
            node_par[c] = 12'(from);
            if (!node_opn[c]) begin
               node_opn[c] = 1;
               open_cnt++;
            end
         end
      end
   endfunction

   function automatic void run_search();
      int w, h, start, goal, best, steps, cur;
      logic [23:0] best_f;
      bit have;
      w = clamp_dim(reg_w);
      h = clamp_dim(reg_h);
      open_cnt = 0;
      for (int i = 0; i < CELLS; i++) begin
         node_opn[i] = 0;
         node_cls[i] = 0;
      end
      path_cnt = 0;
      path_ok = 0;
      if (reg_sx >= w || reg_sy >= h || reg_gx >= w || reg_gy >= h) return;
      start = reg_sy * SIDE + reg_sx;
      goal = reg_gy * SIDE + reg_gx;
      node_g[start] = 16'd0;
      expand_cell(reg_sx, reg_sy, w, h);
      while (open_cnt > 0) begin
         have = 0;
         best = 0;
         best_f = 0;
         // ties go to the first cell in x-then-y order
         for (int x = 0; x < w; x++)
            for (int y = 0; y < h; y++)
               if (node_opn[y * SIDE + x] && (!have || node_f[y * SIDE + x] < best_f)) begin
                  best = y * SIDE + x;
                  best_f = node_f[best];
                  have = 1;
               end
         if (!have) return;
         if (best == goal) begin
            steps = 0;
            cur = goal;
            while (cur != start) begin
               if (steps >= CELLS - 1) return;
               cur = int'(node_par[cur]);
               steps++;
            end
            path_cnt = 13'(steps + 1);
            cur = goal;
            for (int k = steps + 1; k > 0; k--) begin
               path_mem[k - 1] = 12'(cur);
               cur = int'(node_par[cur]);
            end
            path_ok = 1;
            return;
         end
         node_opn[best] = 0;
         open_cnt--;
         expand_cell(best % SIDE, best / SIDE, w, h);
      end
   endfunction

   function automatic rsp_word_type predict_word(req_word_type wd);
      rsp_word_type r;
      r = '0;
      case (wd.opcode)
         OP_WRITE:  map_blk[wd.cell_y * SIDE + wd.cell_x] = wd.blocked;
         OP_SEARCH: run_search();
         OP_READ: begin
            if (wd.path_index < path_cnt) begin
               r.path_x = path_mem[wd.path_index][5:0];
               r.path_y = path_mem[wd.path_index][11:6];
            end
         end
         default: ;
      endcase
      r.found = path_ok;
      r.path_length = path_cnt;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // ---------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------
   // valid is left high on return, so back-to-back words never drop it
   task automatic send_word(req_word_type wd, bit typed, rsp_word_type want);
      int gap;
      rsp_word_type p;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= wd;
      do @(posedge clock); while (!(req_valid && !req_stall));
      p = predict_word(wd);
      sched_q.push_back(typed ? want : p);
      items_sent++;
   endtask

   task automatic send_cmd(logic [1:0] op, int x, int y, bit b, int idx);
      req_word_type wd;
      wd.opcode = op;
      wd.cell_x = 6'(x);
      wd.cell_y = 6'(y);
      wd.blocked = b;
      wd.path_index = 12'(idx);
      send_word(wd, 0, '0);
   endtask

   // wait until every owed word is back, then a few quiet cycles
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sched_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_put(logic [2:0] idx, logic [6:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_WIDTH_USED:  reg_w = val;
         CSR_HEIGHT_USED: reg_h = val;
         CSR_START_X:     reg_sx = val[5:0];
         CSR_START_Y:     reg_sy = val[5:0];
         CSR_GOAL_X:      reg_gx = val[5:0];
         CSR_GOAL_Y:      reg_gy = val[5:0];
         default: ;
      endcase
   endtask

   task automatic csr_all(int w, int h, int sx, int sy, int gx, int gy);
      csr_put(CSR_WIDTH_USED, 7'(w));
      csr_put(CSR_HEIGHT_USED, 7'(h));
      csr_put(CSR_START_X, 7'(sx));
      csr_put(CSR_START_Y, 7'(sy));
      csr_put(CSR_GOAL_X, 7'(gx));
      csr_put(CSR_GOAL_Y, 7'(gy));
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------
   row_type dir_tab[$];

   function automatic row_type cmd_row(logic [1:0] op, int x, int y, bit b, int idx,
                                       bit typed, bit f, int len);
      row_type r;
      r.kind = ROW_CMD;
      r.idx = '0;
      r.val = '0;
      r.word.opcode = op;
      r.word.cell_x = 6'(x);
      r.word.cell_y = 6'(y);
      r.word.blocked = b;
      r.word.path_index = 12'(idx);
      r.typed = typed;
      r.rsp = '0;
      r.rsp.found = f;
      r.rsp.path_length = 13'(len);
      return r;
   endfunction

   function automatic row_type csr_row(logic [2:0] idx, int val);
      row_type r;
      r = cmd_row(OP_NOP, 0, 0, 0, 0, 0, 0, 0);
      r.kind = ROW_CSR;
      r.idx = idx;
      r.val = 7'(val);
      return r;
   endfunction

   task automatic build_table();
      // after reset: no path, start and goal both at the origin
      dir_tab.push_back(cmd_row(OP_READ, 0, 0, 0, 0, 1, 0, 0));
      dir_tab.push_back(cmd_row(OP_NOP, 63, 63, 1, 4095, 1, 0, 0));
      dir_tab.push_back(cmd_row(OP_SEARCH, 0, 0, 0, 0, 1, 1, 1));
      dir_tab.push_back(cmd_row(OP_READ, 0, 0, 0, 0, 1, 1, 1));
      dir_tab.push_back(cmd_row(OP_READ, 0, 0, 0, 4095, 1, 1, 1));   // beyond path
      dir_tab.push_back(cmd_row(OP_WRITE, 63, 63, 1, 0, 1, 1, 1));   // path kept
      dir_tab.push_back(cmd_row(OP_WRITE, 63, 63, 0, 0, 1, 1, 1));
      dir_tab.push_back(cmd_row(OP_WRITE, 0, 0, 1, 0, 1, 1, 1));
      dir_tab.push_back(cmd_row(OP_SEARCH, 0, 0, 0, 0, 0, 0, 0));    // blocked start
      // zero sizes act as one
      dir_tab.push_back(csr_row(CSR_WIDTH_USED, 0));
      dir_tab.push_back(csr_row(CSR_HEIGHT_USED, 0));
      dir_tab.push_back(cmd_row(OP_SEARCH, 0, 0, 0, 0, 0, 0, 0));
      // oversize acts as full map; goal diagonal to start in the far corner
      dir_tab.push_back(csr_row(CSR_WIDTH_USED, 127));
      dir_tab.push_back(csr_row(CSR_HEIGHT_USED, 127));
      dir_tab.push_back(csr_row(CSR_START_X, 62));
      dir_tab.push_back(csr_row(CSR_START_Y, 62));
      dir_tab.push_back(csr_row(CSR_GOAL_X, 63));
      dir_tab.push_back(csr_row(CSR_GOAL_Y, 63));
      dir_tab.push_back(cmd_row(OP_WRITE, 63, 63, 1, 0, 0, 0, 0));   // blocked goal
      dir_tab.push_back(cmd_row(OP_SEARCH, 0, 0, 0, 0, 0, 0, 0));
      dir_tab.push_back(cmd_row(OP_READ, 0, 0, 0, 0, 0, 0, 0));
      dir_tab.push_back(cmd_row(OP_READ, 0, 0, 0, 1, 0, 0, 0));
      dir_tab.push_back(cmd_row(OP_READ, 0, 0, 0, 2, 0, 0, 0));
      // goal outside the region in use
      dir_tab.push_back(csr_row(CSR_WIDTH_USED, 4));
      dir_tab.push_back(cmd_row(OP_SEARCH, 0, 0, 0, 0, 1, 0, 0));
      dir_tab.push_back(cmd_row(OP_WRITE, 63, 63, 0, 0, 1, 0, 0));
      dir_tab.push_back(cmd_row(OP_WRITE, 0, 0, 0, 0, 1, 0, 0));
   endtask

   // ---------------------------------------------------------------
   // Random phases
   // ---------------------------------------------------------------
   task automatic small_phase();
      int w, h, nw, nr;
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 7) == 0)
         csr_all(w, h, $urandom_range(0, 63), $urandom_range(0, 63),
                 $urandom_range(0, 63), $urandom_range(0, 63));
      else
         csr_all(w, h, $urandom_range(0, clamp_dim(7'(w)) - 1),
                 $urandom_range(0, clamp_dim(7'(h)) - 1),
                 $urandom_range(0, clamp_dim(7'(w)) - 1),
                 $urandom_range(0, clamp_dim(7'(h)) - 1));
      nw = $urandom_range(2, 6);
      repeat (nw)
         send_cmd(OP_WRITE, $urandom_range(0, clamp_dim(7'(w)) - 1),
                  $urandom_range(0, clamp_dim(7'(h)) - 1), $urandom_range(0, 2) == 0, 0);
      send_cmd(OP_SEARCH, 0, 0, 0, 0);
      nr = $urandom_range(1, 4);
      repeat (nr)
         send_cmd(OP_READ, 0, 0, 0, (path_cnt > 0) ? $urandom_range(0, path_cnt - 1) : 0);
      send_cmd(OP_READ, 0, 0, 0, path_cnt);
      // noise: full-range fields, status opcode, stray map writes
      case ($urandom_range(0, 2))
         0: send_cmd(OP_NOP, $urandom, $urandom, $urandom, $urandom);
         1: send_cmd(OP_READ, $urandom, $urandom, $urandom, $urandom_range(0, 4095));
         default: send_cmd(OP_WRITE, $urandom, $urandom, 0, $urandom);
      endcase
   endtask

   // full map, goal at or one step from start so the scan count stays low
   task automatic big_phase();
      int sx, sy, gx, gy;
      sx = $urandom_range(0, 63);
      sy = $urandom_range(0, 63);
      gx = sx + $urandom_range(0, 2) - 1;
      gy = sy + $urandom_range(0, 2) - 1;
      if (gx < 0 || gx > 63) gx = sx;
      if (gy < 0 || gy > 63) gy = sy;
      csr_all($urandom_range(64, 127), $urandom_range(64, 127), sx, sy, gx, gy);
      send_cmd(OP_SEARCH, 0, 0, 0, 0);
      send_cmd(OP_READ, 0, 0, 0, 0);
      send_cmd(OP_READ, 0, 0, 0, 1);
   endtask

   // receiver holds off while back-to-back writes fill the block
   task automatic pressure_phase();
      quiet = 1;
      hold_long = 1;
      repeat (10)
         send_cmd(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63), 0, 0);
      quiet = 0;
   endtask

   // ---------------------------------------------------------------
   // Receiver: random stalls, checks each word against the oldest owed
   // ---------------------------------------------------------------
   initial begin
      int n;
      rsp_word_type want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         n = $urandom_range(0, 11);
         if ($urandom_range(0, 3) == 0) n = 0;
         if (hold_long) begin
            n = 400;
            hold_long = 0;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         if (sched_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_word, 0);
         end else begin
            want = sched_q.pop_front();
            if (rsp_word.found !== want.found)
               report_mismatch("found", rsp_word.found, want.found);
            if (rsp_word.path_length !== want.path_length)
               report_mismatch("path_length", rsp_word.path_length, want.path_length);
            if (rsp_word.path_x !== want.path_x)
               report_mismatch("path_x", rsp_word.path_x, want.path_x);
            if (rsp_word.path_y !== want.path_y)
               report_mismatch("path_y", rsp_word.path_y, want.path_y);
         end
      end
   end

   // watchdog: long searches move no word, so the limit is generous
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout waiting for a word");
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int ph;
      errors = 0;
      items_sent = 0;
      quiet = 0;
      hold_long = 0;
      for (int i = 0; i < CELLS; i++) begin
         map_blk[i] = 0;
         node_g[i] = 0;
         node_f[i] = 0;
         node_par[i] = 0;
         node_opn[i] = 0;
         node_cls[i] = 0;
         path_mem[i] = 0;
      end
      path_cnt = 0;
      path_ok = 0;
      reg_w = 64;
      reg_h = 64;
      reg_sx = 0;
      reg_sy = 0;
      reg_gx = 0;
      reg_gy = 0;
      build_table();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR) begin
            drain();
            csr_put(dir_tab[i].idx, dir_tab[i].val);
            csr_wr_en <= 1'b0;
         end else begin
            send_word(dir_tab[i].word, dir_tab[i].typed, dir_tab[i].rsp);
         end
      end

      ph = 0;
      while (items_sent < ITEM_GOAL) begin
         drain();
         quiet = ($urandom_range(0, 4) == 0);
         if (ph == 3)
            pressure_phase();
         else if (ph == 5 || ph == 11)
            big_phase();
         else
            small_phase();
         ph++;
      end

      drain();
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
